// File: hw/rtl/cacs_pkg.sv
// Shared types and constants for the cave smoothing unit.
package cacs_pkg;

    localparam int DIM    = 32;
    localparam int ROW_W  = 32;
    localparam int ADDR_W = 5;
    localparam int CNT_W  = 6;
    localparam int THR_W  = 4;
    localparam int NBR_W  = 8;
    localparam int POP_W  = 4;

    localparam logic [ROW_W-1:0] ROW_ONES = '1;

    // Register map, word index from paddr[3:2]
    localparam logic [1:0] REG_PASS_COUNT   = 2'd0;
    localparam logic [1:0] REG_BIRTH_THR    = 2'd1;
    localparam logic [1:0] REG_SURVIVE_THR  = 2'd2;

    localparam logic [THR_W-1:0] PASS_COUNT_RST  = 4'd5;
    localparam logic [THR_W-1:0] BIRTH_THR_RST   = 4'd5;
    localparam logic [THR_W-1:0] SURVIVE_THR_RST = 4'd4;

    typedef struct packed {
        logic [THR_W-1:0] birth;
        logic [THR_W-1:0] survive;
    } thr_t;

    // One row entering the window; idx == DIM is the wall row below the grid
    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] idx;
        logic [ROW_W-1:0] row;
    } feed_t;

    // One smoothed row ready to be written back
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
        logic [ROW_W-1:0]  row;
    } row_wr_t;

endpackage

// File: hw/rtl/cacs_lane.sv
// One column lane: counts wall neighbors and applies the birth/survive rule.
module cacs_lane
    import cacs_pkg::*;
(
    input  logic [NBR_W-1:0] nbr,
    input  logic             self_bit,
    input  thr_t             thr,
    output logic             wall
);

    logic [POP_W-1:0] walls;

    always_comb
    begin
        walls = '0;
        for (int i = 0; i < NBR_W; i++)
        begin
            walls = walls + POP_W'(nbr[i]);
        end
        wall = (walls >= thr.birth) || (self_bit && (walls >= thr.survive));
    end

endmodule

// File: hw/rtl/cacs_row_unit.sv
// Three-row window, one lane per column, and the row merge register.
module cacs_row_unit
    import cacs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  feed_t   feed,
    input  thr_t    thr,
    output row_wr_t wr
);

    logic [ROW_W-1:0] up_reg;
    logic [ROW_W-1:0] cur_reg;
    logic [ROW_W+1:0] pad_up;
    logic [ROW_W+1:0] pad_cur;
    logic [ROW_W+1:0] pad_dn;
    logic [ROW_W-1:0] lane_bits;
    logic             wr_vld_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [ROW_W-1:0] wr_row_reg;

    // Slide the window; the row above the grid is all walls
    always_ff @(posedge clk)
    begin
        if (feed.vld)
        begin
            up_reg  <= (feed.idx == '0) ? ROW_ONES : cur_reg;
            cur_reg <= feed.row;
        end
    end

    // Pad left and right edges with walls
    assign pad_up  = {1'b1, up_reg,   1'b1};
    assign pad_cur = {1'b1, cur_reg,  1'b1};
    assign pad_dn  = {1'b1, feed.row, 1'b1};

    for (genvar x = 0; x < ROW_W; x++)
    begin : g_lane
        cacs_lane u_lane (
            .nbr      ({pad_up[x], pad_up[x+1], pad_up[x+2],
                        pad_cur[x], pad_cur[x+2],
                        pad_dn[x], pad_dn[x+1], pad_dn[x+2]}),
            .self_bit (pad_cur[x+1]),
            .thr      (thr),
            .wall     (lane_bits[x])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_vld_reg <= 1'b0;
        end
        else
        begin
            wr_vld_reg <= feed.vld && (feed.idx != '0);
        end
    end

    // Merge lane bits into the finished row for the center of the window
    always_ff @(posedge clk)
    begin
        if (feed.vld)
        begin
            wr_addr_reg <= ADDR_W'(feed.idx - CNT_W'(1));
            wr_row_reg  <= lane_bits;
        end
    end

    assign wr.vld  = wr_vld_reg;
    assign wr.addr = wr_addr_reg;
    assign wr.row  = wr_row_reg;

endmodule

// File: hw/rtl/cave_cellular_automaton_smoother_unit.sv
// Top level of the cave smoothing unit: control, grid memory and ports.
// Load: one row word per cycle; the word with tlast starts processing.
// Then a zero fill of the rows that were not loaded, pass_count passes that each
// feed the 32 grid rows plus the wall row below, one row through the lane array per
// cycle, and output of each row through read, load and hold while m_tready stays high.
// Reset: control and registers return to pass 5, birth 5, survive 4; the grid
// memory is not cleared.
module cave_cellular_automaton_smoother_unit
    import cacs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Input row stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ROW_W-1:0]  s_tdata,   // [31:0] row_bits
    input  logic              s_tlast,   // last_row
    // Output row stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ROW_W-1:0]  m_tdata,   // [31:0] result_row_bits
    output logic              m_tlast,   // result_last
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_PASS,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  row_counter_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [THR_W-1:0]  pass_counter_reg;
    logic [CNT_W-1:0]  feed_idx_reg;
    logic [ADDR_W-1:0] emit_ptr_reg;
    logic              a_vld_reg;
    logic [CNT_W-1:0]  a_idx_reg;
    logic              m_vld_reg;
    logic              m_last_reg;
    logic [ROW_W-1:0]  m_data_reg;

    logic [THR_W-1:0]  pass_count_reg;
    logic [THR_W-1:0]  birth_reg;
    logic [THR_W-1:0]  survive_reg;

    logic [ROW_W-1:0]  grid_mem [DIM];
    logic [ROW_W-1:0]  rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              ld_wen;
    logic [ADDR_W-1:0] ld_waddr;
    logic [ROW_W-1:0]  ld_wdata;

    logic              s_acc;
    logic              cfg_wr;
    feed_t             feed;
    thr_t              thr;
    row_wr_t           row_wr;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_count_reg <= PASS_COUNT_RST;
            birth_reg      <= BIRTH_THR_RST;
            survive_reg    <= SURVIVE_THR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PASS_COUNT:  pass_count_reg <= pwdata[THR_W-1:0];
                REG_BIRTH_THR:   birth_reg      <= pwdata[THR_W-1:0];
                REG_SURVIVE_THR: survive_reg    <= pwdata[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PASS_COUNT:  prdata = 32'(pass_count_reg);
            REG_BIRTH_THR:   prdata = 32'(birth_reg);
            REG_SURVIVE_THR: prdata = 32'(survive_reg);
            default:         prdata = '0;
        endcase
    end

    assign thr.birth   = birth_reg;
    assign thr.survive = survive_reg;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;

    // Rows held after this word; words beyond the grid are dropped
    assign fill_next = (row_counter_reg < CNT_W'(DIM)) ? row_counter_reg + CNT_W'(1)
                                                       : row_counter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            row_counter_reg  <= '0;
            pass_counter_reg <= '0;
            feed_idx_reg     <= '0;
            emit_ptr_reg     <= '0;
            a_vld_reg        <= 1'b0;
            a_idx_reg        <= '0;
            m_vld_reg        <= 1'b0;
            m_last_reg       <= 1'b0;
            m_data_reg       <= '0;
        end
        else
        begin
            // A row read is in flight for every pass cycle
            a_vld_reg <= (state_reg == ST_PASS);
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (s_acc)
                    begin
                        if (s_tlast && (fill_next == CNT_W'(DIM)))
                        begin
                            row_counter_reg <= '0;
                            emit_ptr_reg    <= '0;
                            feed_idx_reg    <= '0;
                            state_reg <= (pass_count_reg == '0) ? ST_EMIT_RD : ST_PASS;
                        end
                        else
                        begin
                            row_counter_reg <= fill_next;
                            if (s_tlast)
                            begin
                                state_reg <= ST_CLEAR;
                            end
                        end
                    end
                end
                ST_CLEAR:
                begin
                    // Zero the rows that were never delivered
                    if (row_counter_reg == CNT_W'(DIM - 1))
                    begin
                        row_counter_reg <= '0;
                        emit_ptr_reg    <= '0;
                        feed_idx_reg    <= '0;
                        state_reg <= (pass_count_reg == '0) ? ST_EMIT_RD : ST_PASS;
                    end
                    else
                    begin
                        row_counter_reg <= row_counter_reg + CNT_W'(1);
                    end
                end
                ST_PASS:
                begin
                    // Issue one row read per cycle, then the wall row below
                    a_idx_reg <= feed_idx_reg;
                    if (feed_idx_reg == CNT_W'(DIM))
                    begin
                        feed_idx_reg <= '0;
                        if (pass_counter_reg + THR_W'(1) == pass_count_reg)
                        begin
                            pass_counter_reg <= '0;
                            state_reg        <= ST_EMIT_RD;
                        end
                        else
                        begin
                            pass_counter_reg <= pass_counter_reg + THR_W'(1);
                        end
                    end
                    else
                    begin
                        feed_idx_reg <= feed_idx_reg + CNT_W'(1);
                    end
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_LD;
                end
                ST_EMIT_LD:
                begin
                    m_vld_reg  <= 1'b1;
                    m_last_reg <= (emit_ptr_reg == ADDR_W'(DIM - 1));
                    m_data_reg <= rdata_reg;
                    state_reg  <= ST_EMIT_HOLD;
                end
                ST_EMIT_HOLD:
                begin
                    // Hold the word until taken, then advance
                    if (m_tready)
                    begin
                        m_vld_reg <= 1'b0;
                        if (m_last_reg)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            emit_ptr_reg <= emit_ptr_reg + ADDR_W'(1);
                            state_reg    <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Grid memory: one write port, one registered read port
    // ------------------------------------------------------------------
    assign rd_addr = (state_reg == ST_PASS) ? feed_idx_reg[ADDR_W-1:0] : emit_ptr_reg;

    always_comb
    begin
        ld_wen   = 1'b0;
        ld_waddr = row_counter_reg[ADDR_W-1:0];
        ld_wdata = '0;
        if (state_reg == ST_LOAD)
        begin
            ld_wen   = s_acc && (row_counter_reg < CNT_W'(DIM));
            ld_wdata = s_tdata;
        end
        else if (state_reg == ST_CLEAR)
        begin
            ld_wen = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= grid_mem[rd_addr];
        if (row_wr.vld)
        begin
            grid_mem[row_wr.addr] <= row_wr.row;
        end
        else if (ld_wen)
        begin
            grid_mem[ld_waddr] <= ld_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Smoothing datapath; writes trail the reads, so in-place update is safe
    // ------------------------------------------------------------------
    assign feed.vld = a_vld_reg;
    assign feed.idx = a_idx_reg;
    assign feed.row = (a_idx_reg == CNT_W'(DIM)) ? ROW_ONES : rdata_reg;

    cacs_row_unit u_row_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (feed),
        .thr   (thr),
        .wr    (row_wr)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && s_tready))
        else $error("output word pending while input is open");

    a_wb_not_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        row_wr.vld |-> (state_reg != ST_LOAD) && (state_reg != ST_CLEAR))
        else $error("pass write-back collides with load or clear");

    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input stays open after last row");

    a_last_is_final_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == ST_LOAD) && !m_tvalid)
        else $error("output continues after final row");

endmodule

// File: sim/tb_top.sv
// Self-checking bench for the cave smoothing unit: row words in, smoothed grid words out.
module tb_top
    import cacs_pkg::*;
();

    localparam int STALL_MAX   = 12;    // longest gap either side draws per word
    localparam int QUIET_LIMIT = 6000;  // cycles with no word moving before giving up
    localparam int RANDOM_ROWS = 250;   // grid rows to load in the random phase
    localparam int SETTLE      = 8;     // idle cycles before touching registers
    localparam int TAIL        = 40;    // cycles to watch for stray words at the end

    // One expected output word
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             last;
    } grid_row_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [ROW_W-1:0] s_tdata  = '0;     // [31:0] row_bits
    logic             s_tlast  = 1'b0;   // last_row
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [ROW_W-1:0] m_tdata;           // [31:0] result_row_bits
    logic             m_tlast;           // result_last
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [3:0]       paddr    = '0;
    logic [31:0]      pwdata   = '0;
    logic [31:0]      prdata;
    logic             pready;

    // Predictor state: the grid as the block should hold it, plus its registers
    logic [ROW_W-1:0] cave_grid [DIM];
    int               rows_loaded = 0;
    logic [THR_W-1:0] pass_cfg    = PASS_COUNT_RST;
    logic [THR_W-1:0] birth_cfg   = BIRTH_THR_RST;
    logic [THR_W-1:0] survive_cfg = SURVIVE_THR_RST;
    grid_row_t        smoothed_q [$];

    // Idling controls, flipped per grid so that some grids run flat out
    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b1;
    int               rx_hold    = 0;
    int               quiet_cycles = 0;
    int               mismatches   = 0;
    int               rows_checked = 0;
    grid_row_t        next_expected;

    cave_cellular_automaton_smoother_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Cells past any edge of the grid count as walls.
    function automatic int wall_at(int x, int y);
        if (x < 0 || x >= DIM || y < 0 || y >= DIM)
            return 1;
        return int'(cave_grid[y][x]);
    endfunction

    // One synchronous pass: every cell is judged on the old grid.
    function automatic void smooth_pass();
        logic [ROW_W-1:0] next_grid [DIM];
        int               walls;
        for (int y = 0; y < DIM; y++)
        begin
            next_grid[y] = '0;
            for (int x = 0; x < DIM; x++)
            begin
                walls = 0;
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if (dx != 0 || dy != 0)
                            walls += wall_at(x + dx, y + dy);
                // Birth fires on any cell; survival only keeps an existing wall
                if (walls >= int'(birth_cfg) ||
                    (cave_grid[y][x] && walls >= int'(survive_cfg)))
                    next_grid[y][x] = 1'b1;
            end
        end
        cave_grid = next_grid;
    endfunction

    // Take one accepted row word; a last word runs the passes and queues the grid.
    function automatic void absorb_row(logic [ROW_W-1:0] row, logic last);
        // Drop rows once the grid is full, the last word's row included
        if (rows_loaded < DIM)
        begin
            cave_grid[rows_loaded] = row;
            rows_loaded++;
        end
        if (last)
        begin
            // Clear rows a short grid never delivered
            for (int y = rows_loaded; y < DIM; y++)
                cave_grid[y] = '0;
            repeat (pass_cfg)
                smooth_pass();
            for (int y = 0; y < DIM; y++)
                smoothed_q.push_back('{row: cave_grid[y], last: (y == DIM - 1)});
            rows_loaded = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one row word, idling a random number of cycles first when tx_idle_on is set.
    task automatic send_row(input logic [ROW_W-1:0] row, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, STALL_MAX) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_row(row, last);
    endtask

    // Drop valid and hold until every expected word has come out.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (smoothed_q.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic set_reg(input logic [1:0] reg_idx, input logic [THR_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {28'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (reg_idx)
            REG_PASS_COUNT:  pass_cfg    = value;
            REG_BIRTH_THR:   birth_cfg   = value;
            REG_SURVIVE_THR: survive_cfg = value;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait for the block to go idle, then load all three registers.
    task automatic reconfigure(input logic [THR_W-1:0] passes,
                               input logic [THR_W-1:0] birth,
                               input logic [THR_W-1:0] survive);
        drain_results();
        repeat (SETTLE) @(posedge clk);
        set_reg(REG_PASS_COUNT, passes);
        set_reg(REG_BIRTH_THR, birth);
        set_reg(REG_SURVIVE_THR, survive);
    endtask

    // Output side: stall a random number of cycles after each accepted word when rx_idle_on is set.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: row %0d %s got %h want %h", rows_checked, what, got, want);
        mismatches++;
    endtask

    // Compare each accepted output word with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (smoothed_q.size() == 0)
                report_mismatch("unexpected word", m_tdata, '0);
            else
            begin
                next_expected = smoothed_q.pop_front();
                if (m_tdata !== next_expected.row)
                    report_mismatch("row bits", m_tdata, next_expected.row);
                if (m_tlast !== next_expected.last)
                    report_mismatch("last flag", {31'd0, m_tlast}, {31'd0, next_expected.last});
            end
            rows_checked++;
            rx_hold = rx_idle_on ? $urandom_range(0, STALL_MAX) : 0;
        end
    end

    // Watchdog: give up when no word moves on either side for too long.
    // This also catches expected words that never arrive.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers untouched: a one-row grid of walls, then a three-row grid.
    task automatic test_reset_defaults();
        send_row(ROW_ONES, 1'b1);
        send_row('0, 1'b0);
        send_row(32'h8000_0001, 1'b0);
        send_row(32'h5555_5555, 1'b1);
        drain_results();
    endtask

    // No passes: the loaded grid comes back as is, unloaded rows open.
    task automatic test_zero_passes();
        reconfigure(4'd0, BIRTH_THR_RST, SURVIVE_THR_RST);
        send_row(32'hDEAD_BEEF, 1'b1);
    endtask

    // Thresholds at zero, at eight and beyond anything the count can reach.
    task automatic test_threshold_extremes();
        reconfigure(4'd15, 4'd0, 4'd4);
        send_row('0, 1'b1);
        reconfigure(4'd1, 4'd15, 4'd15);
        send_row(ROW_ONES, 1'b0);
        send_row(32'h0F0F_0F0F, 1'b1);
        reconfigure(4'd3, 4'd8, 4'd0);
        send_row(32'h1234_5678, 1'b0);
        send_row(32'hFFFF_0000, 1'b1);
        reconfigure(4'd2, 4'd9, 4'd8);
        send_row(32'h0000_FFFF, 1'b1);
        drain_results();
    endtask

    // Random grids: mostly well-formed, some full, some overlong, random settings.
    task automatic test_random_grids();
        int               loaded;
        int               grid_len;
        logic [ROW_W-1:0] row;
        loaded = 0;
        while (loaded < RANDOM_ROWS)
        begin
            if ($urandom_range(0, 2) == 0)
                reconfigure(THR_W'($urandom_range(0, 15)),
                            THR_W'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                               : $urandom_range(0, 8)),
                            THR_W'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                               : $urandom_range(0, 8)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       grid_len = $urandom_range(DIM + 1, DIM + 8);
                1, 2, 3: grid_len = DIM;
                default: grid_len = $urandom_range(1, DIM - 1);
            endcase
            for (int i = 0; i < grid_len; i++)
            begin
                // Vary wall density so the passes see sparse, dense and solid rows
                case ($urandom_range(0, 4))
                    0:       row = $urandom() & $urandom();
                    1:       row = $urandom() | $urandom();
                    2:       row = $urandom_range(0, 1) ? ROW_ONES : '0;
                    default: row = $urandom();
                endcase
                send_row(row, i == grid_len - 1);
            end
            loaded += (grid_len < DIM) ? grid_len : DIM;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_passes();
        test_threshold_extremes();
        test_random_grids();

        drain_results();
        repeat (TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/cacs_pkg.sv
hw/rtl/cacs_lane.sv
hw/rtl/cacs_row_unit.sv
hw/rtl/cave_cellular_automaton_smoother_unit.sv
sim/tb_top.sv
